// ===== rtl/atc_pkg.sv =====
// Shared types, constants and table functions for the ADC telemetry conversion block.
// No dependencies; every other file of the block imports this package.
package atc_pkg;

  localparam int ChannelsDef     = 24;
  localparam int TableEntriesDef = 166;
  localparam int RoleChannels    = 24;   // channels that have role bits
  localparam int NtcEntries      = 166;  // entries in the thermistor table
  localparam int RefMv           = 3300;
  localparam int CodeBits        = 12;
  localparam int CodeSpan        = 1 << CodeBits;
  localparam int TempOffset      = 40;
  localparam int ChW             = 5;
  localparam int MvW             = 13;
  localparam int DegW            = 8;
  localparam int CfgDataW        = 64;
  localparam int CfgAddrW        = 5;
  localparam logic [CodeBits-1:0] ThreshReset = 12'd1650;

  // Register index = paddr[4:3]
  localparam logic [1:0] RegRoles  = 2'd0;
  localparam logic [1:0] RegDouble = 2'd1;
  localparam logic [1:0] RegThresh = 2'd2;

  typedef enum logic [1:0] {
    KIND_UNUSED = 2'd0,
    KIND_TEMP   = 2'd1,
    KIND_VOLT   = 2'd2,
    KIND_FLAG   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [RoleChannels-1:0][1:0]  roles;
    logic [RoleChannels-1:0]       dbl_mask;
    logic [CodeBits-1:0]           threshold;
  } cfg_t;

  typedef struct packed {
    logic [ChW-1:0]         source_channel;
    kind_t                  kind;
    logic [MvW-1:0]         millivolts;
    logic signed [DegW-1:0] degrees_c;
    logic                   power_good;
  } res_t;

  // Thermistor divider voltage in mV, one entry per degree from -40 C.
  localparam logic [11:0] NtcMv [NtcEntries] = '{
    12'd3134, 12'd3125, 12'd3116, 12'd3106, 12'd3096, 12'd3086, 12'd3075, 12'd3064,
    12'd3053, 12'd3041, 12'd3028, 12'd3015, 12'd3002, 12'd2988, 12'd2973, 12'd2958,
    12'd2943, 12'd2927, 12'd2910, 12'd2893, 12'd2876, 12'd2858, 12'd2839, 12'd2820,
    12'd2800, 12'd2780, 12'd2759, 12'd2738, 12'd2716, 12'd2694, 12'd2671, 12'd2647,
    12'd2623, 12'd2599, 12'd2574, 12'd2549, 12'd2523, 12'd2496, 12'd2470, 12'd2443,
    12'd2415, 12'd2387, 12'd2358, 12'd2330, 12'd2301, 12'd2271, 12'd2241, 12'd2211,
    12'd2181, 12'd2151, 12'd2120, 12'd2089, 12'd2058, 12'd2026, 12'd1995, 12'd1964,
    12'd1932, 12'd1901, 12'd1870, 12'd1838, 12'd1806, 12'd1775, 12'd1743, 12'd1712,
    12'd1681, 12'd1650, 12'd1619, 12'd1589, 12'd1558, 12'd1528, 12'd1498, 12'd1468,
    12'd1439, 12'd1410, 12'd1381, 12'd1352, 12'd1324, 12'd1296, 12'd1269, 12'd1241,
    12'd1215, 12'd1188, 12'd1162, 12'd1137, 12'd1112, 12'd1087, 12'd1063, 12'd1038,
    12'd1015, 12'd992,  12'd969,  12'd947,  12'd925,  12'd904,  12'd883,  12'd862,
    12'd842,  12'd822,  12'd803,  12'd784,  12'd765,  12'd747,  12'd729,  12'd712,
    12'd695,  12'd678,  12'd662,  12'd646,  12'd631,  12'd616,  12'd601,  12'd587,
    12'd573,  12'd559,  12'd546,  12'd532,  12'd520,  12'd507,  12'd495,  12'd483,
    12'd472,  12'd461,  12'd450,  12'd439,  12'd428,  12'd418,  12'd408,  12'd399,
    12'd389,  12'd380,  12'd371,  12'd362,  12'd354,  12'd346,  12'd337,  12'd330,
    12'd322,  12'd315,  12'd307,  12'd300,  12'd293,  12'd287,  12'd280,  12'd274,
    12'd267,  12'd261,  12'd255,  12'd250,  12'd244,  12'd238,  12'd233,  12'd228,
    12'd223,  12'd218,  12'd213,  12'd208,  12'd204,  12'd199,  12'd195,  12'd191,
    12'd186,  12'd182,  12'd179,  12'd175,  12'd171,  12'd167
  };

  // Smallest raw code whose millivolt value exceeds the midpoint of entries k and k+1:
  // floor(c*RefMv/CodeSpan) > mid  <=>  c >= ceil((mid+1)*CodeSpan/RefMv).
  function automatic logic [CodeBits-1:0] code_threshold(int k);
    int mid;
    int num;
    mid = (int'(NtcMv[k]) + int'(NtcMv[k+1])) / 2;
    num = (mid + 1) * CodeSpan;
    return CodeBits'((num + RefMv - 1) / RefMv);
  endfunction

endpackage

// ===== rtl/atc_if.sv =====
// Valid/ready channel interfaces for samples in and converted results out.
// Depends on atc_pkg.
interface atc_in_if import atc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ChW-1:0]       channel;
  logic [CodeBits-1:0]  raw_code;

  modport source (output valid, output channel, output raw_code, input ready);
  modport sink   (input valid, input channel, input raw_code, output ready);
endinterface

interface atc_out_if import atc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ChW-1:0]         source_channel;
  kind_t                  kind;
  logic [MvW-1:0]         millivolts;
  logic signed [DegW-1:0] degrees_c;
  logic                   power_good;

  modport source (output valid, output source_channel, output kind, output millivolts,
                  output degrees_c, output power_good, input ready);
  modport sink   (input valid, input source_channel, input kind, input millivolts,
                  input degrees_c, input power_good, output ready);
endinterface

// ===== rtl/atc_cfg_regs.sv =====
// APB-style configuration registers: channel roles, doubling mask, flag threshold.
// Depends on atc_pkg.
module atc_cfg_regs import atc_pkg::*; #(
  parameter int ROLE_CH = RoleChannels
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic [ROLE_CH-1:0][1:0] roles_r;
  logic [ROLE_CH-1:0]      dbl_r;
  logic [CodeBits-1:0]     thresh_r;
  logic                    wr_en;
  logic [1:0]              reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roles_r  <= '0;
      dbl_r    <= '0;
      thresh_r <= ThreshReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegRoles:  roles_r  <= pwdata[2*ROLE_CH-1:0];
        RegDouble: dbl_r    <= pwdata[ROLE_CH-1:0];
        RegThresh: thresh_r <= pwdata[CodeBits-1:0];
        default: ;  // unmapped, drop the write
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegRoles:  prdata = CfgDataW'(roles_r);
      RegDouble: prdata = CfgDataW'(dbl_r);
      RegThresh: prdata = CfgDataW'(thresh_r);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o.roles     = (2*RoleChannels)'(roles_r);
  assign cfg_o.dbl_mask  = RoleChannels'(dbl_r);
  assign cfg_o.threshold = thresh_r;

endmodule

// ===== rtl/atc_ntc_lookup.sv =====
// Parallel thermistor lookup: raw code against precomputed midpoint codes.
// Depends on atc_pkg.
module atc_ntc_lookup import atc_pkg::*; #(
  parameter int TAB_N = NtcEntries
) (
  input  logic [CodeBits-1:0]    code,
  output logic signed [DegW-1:0] degrees_c
);

  localparam int Cmp = TAB_N - 1;

  logic [Cmp-1:0]          above;   // thermometer: set from the matching index onward
  logic [Cmp-1:0]          first;
  logic [7:0][Cmp-1:0]     bit_sel;
  logic [7:0]              hit_idx;
  logic [7:0]              idx;

  always_comb begin
    for (int k = 0; k < Cmp; k++) begin
      above[k] = (code >= code_threshold(k));
    end
    first[0] = above[0];
    for (int k = 1; k < Cmp; k++) begin
      first[k] = above[k] & ~above[k-1];
    end
    for (int b = 0; b < 8; b++) begin
      for (int k = 0; k < Cmp; k++) begin
        bit_sel[b][k] = first[k] & ((k >> b) & 1) == 1;
      end
      hit_idx[b] = |bit_sel[b];
    end
  end

  // No midpoint exceeded: reading is below the table, take the last index.
  assign idx       = above[Cmp-1] ? hit_idx : 8'(TAB_N - 1);
  assign degrees_c = DegW'(idx) - DegW'(TempOffset);

endmodule

// ===== rtl/atc_convert.sv =====
// Per-sample conversion: code to millivolts, role decode and per-role result.
// Depends on atc_pkg and atc_ntc_lookup.
module atc_convert import atc_pkg::*; #(
  parameter int ROLE_CH = RoleChannels,
  parameter int TAB_N   = NtcEntries
) (
  input  logic [ChW-1:0]      channel,
  input  logic [CodeBits-1:0] raw_code,
  input  cfg_t                cfg_i,
  output res_t                res_o
);

  logic [2*CodeBits-1:0]  prod;
  logic [CodeBits-1:0]    mv;
  logic                   in_range;
  kind_t                  role;
  logic signed [DegW-1:0] deg;

  atc_ntc_lookup #(.TAB_N(TAB_N)) u_lookup (
    .code      (raw_code),
    .degrees_c (deg)
  );

  assign prod     = (2*CodeBits)'(raw_code) * (2*CodeBits)'(RefMv);
  assign mv       = prod[2*CodeBits-1:CodeBits];
  assign in_range = (channel < ChW'(ROLE_CH));
  assign role     = in_range ? kind_t'(cfg_i.roles[channel]) : KIND_UNUSED;

  always_comb begin
    res_o                = '0;
    res_o.source_channel = channel;
    res_o.kind           = role;
    unique case (role)
      KIND_TEMP: begin
        res_o.millivolts = MvW'(mv);
        res_o.degrees_c  = deg;
      end
      KIND_VOLT: begin
        res_o.millivolts = cfg_i.dbl_mask[channel] ? {mv, 1'b0} : MvW'(mv);
      end
      KIND_FLAG: begin
        res_o.millivolts = MvW'(mv);
        res_o.power_good = (mv > cfg_i.threshold);
      end
      KIND_UNUSED: ;
      default: ;
    endcase
  end

endmodule

// ===== rtl/adc_telemetry_conversion.sv =====
// Top level of the ADC telemetry conversion block; instantiates registers and converter.
// Depends on atc_pkg, atc_if, atc_cfg_regs, atc_convert.
//
// Each request on in_if (channel, 12-bit raw code) yields exactly one result on out_if.
// The code is scaled to millivolts as code*3300/4096 and handled by the channel's role
// from channel_roles: temperature reports the nearest entry of a 166-entry thermistor
// table as degrees C (-40..125), voltage passes millivolts (doubled where the channel's
// double_voltage_mask bit is set), power flag reports millivolts above flag_threshold_mv.
// Channels without a role, or at or above CHANNELS, return kind 0 with zero fields.
// Throughput is one request per clock while the sink keeps out_if.ready high; the sample
// register holds the accepted request, the single-pass conversion runs from it, and the
// result register loads the converted result. A stalled sink holds at most two requests,
// one in each register, before in_if.ready drops. Registers sit at byte addresses 0, 8
// and 16 of the 64-bit port; write them only while no request is in flight.
module adc_telemetry_conversion import atc_pkg::*; #(
  parameter int CHANNELS      = ChannelsDef,
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  atc_in_if.sink              in_if,
  atc_out_if.source           out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  // Only the first 24 channels carry role bits; the table caps at its real size.
  localparam int RoleCh = (CHANNELS < RoleChannels) ? CHANNELS : RoleChannels;
  localparam int TabN   = (TABLE_ENTRIES < NtcEntries) ? TABLE_ENTRIES : NtcEntries;

  cfg_t                cfg;
  res_t                res;

  // Sample register
  logic                s1_v_r;
  logic [ChW-1:0]      s1_ch_r;
  logic [CodeBits-1:0] s1_code_r;
  // Result register
  logic                out_v_r;
  res_t                out_res_r;

  logic                out_adv;   // result register can load
  logic                in_take;

  atc_cfg_regs #(.ROLE_CH(RoleCh)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  atc_convert #(.ROLE_CH(RoleCh), .TAB_N(TabN)) u_conv (
    .channel  (s1_ch_r),
    .raw_code (s1_code_r),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // Advance the result register when it is empty or being drained this cycle.
  assign out_adv     = !out_v_r || out_if.ready;
  assign in_if.ready = !s1_v_r || out_adv;
  assign in_take     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch_r   <= in_if.channel;
      s1_code_r <= in_if.raw_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  // Hold the result while the sink stalls; load a fresh one otherwise.
  always_ff @(posedge clk) begin
    if (out_adv && s1_v_r) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid          = out_v_r;
  assign out_if.source_channel = out_res_r.source_channel;
  assign out_if.kind           = out_res_r.kind;
  assign out_if.millivolts     = out_res_r.millivolts;
  assign out_if.degrees_c      = out_res_r.degrees_c;
  assign out_if.power_good     = out_res_r.power_good;

`ifndef ASSERT_OFF
  // A converted sample moves into the result register and becomes visible.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_adv) |=> out_v_r)
    else $error("sample lost between sample and result registers");

  // A stalled result register blocks the sample register only when it is full.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_if.ready) |=> (s1_v_r && out_v_r))
    else $error("request dropped while the sink stalled");

  // Temperature field is zero except on temperature results.
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.kind != KIND_TEMP) |-> (out_res_r.degrees_c == '0))
    else $error("degrees set on a non-temperature result");

  // Power good only on flag results.
  a_pgood: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.power_good) |-> (out_res_r.kind == KIND_FLAG))
    else $error("power_good set on a non-flag result");

  // Reset empties both registers.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!s1_v_r && !out_v_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for adc_telemetry_conversion: scoreboard class, stream drivers, APB writes.
// Depends on atc_pkg (types, register indexes) and atc_if (channel interfaces) from the RTL.
module testbench;
  import atc_pkg::*;

  localparam int NumChannels   = 24;
  localparam int TableLen      = 166;
  localparam int RandomPhases  = 8;
  localparam int PhaseItems    = 241;
  localparam int HoldOffAt     = 700;   // result count that triggers the long receiver stall
  localparam int HoldOffCycles = 400;
  localparam int IdleLimit     = 3000;  // cycles without any handshake before giving up
  localparam int ReportLimit   = 10;

  // Address slot past the last register: writes there must change nothing.
  localparam logic [1:0] RegUnmapped = 2'd3;

  // Thermistor divider voltage in mV, one entry per degree starting at -40 C.
  localparam int ThermistorMv [TableLen] = '{
    3134, 3125, 3116, 3106, 3096, 3086, 3075, 3064, 3053, 3041,
    3028, 3015, 3002, 2988, 2973, 2958, 2943, 2927, 2910, 2893,
    2876, 2858, 2839, 2820, 2800, 2780, 2759, 2738, 2716, 2694,
    2671, 2647, 2623, 2599, 2574, 2549, 2523, 2496, 2470, 2443,
    2415, 2387, 2358, 2330, 2301, 2271, 2241, 2211, 2181, 2151,
    2120, 2089, 2058, 2026, 1995, 1964, 1932, 1901, 1870, 1838,
    1806, 1775, 1743, 1712, 1681, 1650, 1619, 1589, 1558, 1528,
    1498, 1468, 1439, 1410, 1381, 1352, 1324, 1296, 1269, 1241,
    1215, 1188, 1162, 1137, 1112, 1087, 1063, 1038, 1015, 992,
    969, 947, 925, 904, 883, 862, 842, 822, 803, 784,
    765, 747, 729, 712, 695, 678, 662, 646, 631, 616,
    601, 587, 573, 559, 546, 532, 520, 507, 495, 483,
    472, 461, 450, 439, 428, 418, 408, 399, 389, 380,
    371, 362, 354, 346, 337, 330, 322, 315, 307, 300,
    293, 287, 280, 274, 267, 261, 255, 250, 244, 238,
    233, 228, 223, 218, 213, 208, 204, 199, 195, 191,
    186, 182, 179, 175, 171, 167
  };

  // Scoreboard: shadow copy of the registers, the conversion itself, and the queue of
  // readings still owed by the block.
  class conversion_scoreboard;
    logic [47:0] roles;
    logic [23:0] dbl_mask;
    logic [11:0] threshold;
    res_t        pending_readings[$];
    int          checked;
    int          mismatches;

    function new();
      roles      = '0;
      dbl_mask   = '0;
      threshold  = ThreshReset;
      checked    = 0;
      mismatches = 0;
    endfunction

    // Mirror a register write; bits above each register's width drop off.
    function void write_register(logic [1:0] idx, logic [63:0] value);
      case (idx)
        RegRoles:  roles     = value[47:0];
        RegDouble: dbl_mask  = value[23:0];
        RegThresh: threshold = value[11:0];
        default: ;
      endcase
    endfunction

    // Nearest table entry: the first k whose midpoint with k+1 lies below mv, else the last.
    function logic signed [DegW-1:0] degrees_for_mv(int mv);
      int idx;
      int deg;
      int mid;
      idx = TableLen - 1;
      for (int k = TableLen - 2; k >= 0; k--) begin
        mid = (ThermistorMv[k] + ThermistorMv[k + 1]) / 2;
        if (mv > mid) idx = k;
      end
      deg = idx - 40;
      if (deg > 125) deg = 125;
      if (deg < -40) deg = -40;
      return DegW'(deg);
    endfunction

    function res_t convert_sample(logic [ChW-1:0] ch, logic [CodeBits-1:0] code);
      res_t r;
      int   mv;
      mv = (int'(code) * 3300) / 4096;
      r.source_channel = ch;
      r.kind           = KIND_UNUSED;
      r.millivolts     = '0;
      r.degrees_c      = '0;
      r.power_good     = 1'b0;
      // Channels without role bits read as unused.
      if (ch < NumChannels) r.kind = kind_t'(roles[2 * ch +: 2]);
      case (r.kind)
        KIND_TEMP: begin
          r.millivolts = MvW'(mv);
          r.degrees_c  = degrees_for_mv(mv);
        end
        KIND_VOLT: r.millivolts = dbl_mask[ch] ? MvW'(2 * mv) : MvW'(mv);
        KIND_FLAG: begin
          r.millivolts = MvW'(mv);
          r.power_good = (mv > int'(threshold));
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_sample(logic [ChW-1:0] ch, logic [CodeBits-1:0] code);
      pending_readings.push_back(convert_sample(ch, code));
    endfunction

    function void check_result(res_t got);
      res_t want;
      checked++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected result: ch %0d kind %0d mv %0d deg %0d good %0b",
                   got.source_channel, got.kind, got.millivolts, got.degrees_c,
                   got.power_good);
        return;
      end
      want = pending_readings.pop_front();
      if (got.source_channel !== want.source_channel || got.kind !== want.kind ||
          got.millivolts !== want.millivolts || got.degrees_c !== want.degrees_c ||
          got.power_good !== want.power_good) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("mismatch: expected ch %0d kind %0d mv %0d deg %0d good %0b, got ch %0d kind %0d mv %0d deg %0d good %0b",
                   want.source_channel, want.kind, want.millivolts, want.degrees_c,
                   want.power_good, got.source_channel, got.kind, got.millivolts,
                   got.degrees_c, got.power_good);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  atc_in_if  in_ch ();
  atc_out_if out_ch ();

  conversion_scoreboard sb = new();

  // Idle rates for the current phase, in percent; zero means no idling at all.
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int cfg_writes    = 0;

  adc_telemetry_conversion dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // APB write: setup cycle, access cycle, then an idle step so that back-to-back
  // writes never lower and raise psel in the same step. Call only while the block is idle.
  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, value);
    cfg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request and hold it until accepted; then maybe drop valid for a short burst.
  task automatic drive_sample(input int ch, input int code);
    in_ch.valid    <= 1'b1;
    in_ch.channel  <= ChW'(ch);
    in_ch.raw_code <= CodeBits'(code);
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(ChW'(ch), CodeBits'(code));
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every owed reading has come back, plus pipeline slack.
  task automatic finish_burst();
    in_ch.valid <= 1'b0;
    while (sb.pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: check every accepted result, then decide ready for the next cycle.
  // One long hold-off fills the pipeline so that the block has to stall its input.
  initial begin
    int   stall_left;
    bit   held;
    res_t got;
    stall_left = 0;
    held       = 1'b0;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.source_channel = out_ch.source_channel;
        got.kind           = out_ch.kind;
        got.millivolts     = out_ch.millivolts;
        got.degrees_c      = out_ch.degrees_c;
        got.power_good     = out_ch.power_good;
        sb.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!held && sb.checked >= HoldOffAt) begin
        stall_left = HoldOffCycles;
        held       = 1'b1;
      end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
        stall_left = $urandom_range(1, 8);
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  // Watchdog: give up once no request and no result has moved for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d readings outstanding",
                 IdleLimit, sb.pending_readings.size());
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed corners, then random phases under changing settings.
  initial begin
    int          p;
    int          n;
    int          c;
    int          ch;
    int          code;
    int          k;
    int          mid;
    int          th;
    int          failures;
    logic [47:0] roles_v;
    logic [23:0] mask_v;
    logic [11:0] thresh_v;
    logic [63:0] v;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.channel  <= '0;
    in_ch.raw_code <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Channel c gets role c mod 4, so every kind is present; garbage
    // above each register's width must be dropped.
    in_gap_pct    = 0;
    out_stall_pct = 0;
    v = {$urandom, $urandom};
    for (c = 0; c < NumChannels; c++) v[2 * c +: 2] = 2'(c % 4);
    cfg_write(RegRoles, v);
    cfg_write(RegDouble, {40'hFF_FFFF_FFFF, 24'h0F0F0F});

    drive_sample(0, 4095);   // unused channel: all fields zero
    drive_sample(1, 4095);   // above the table: -40
    drive_sample(1, 0);      // below the table: last index
    drive_sample(1, 2048);   // exact hit on the 25 C entry
    drive_sample(1, 3890);   // exact hit on the first entry
    drive_sample(1, 208);    // exact hit on the last entry
    drive_sample(1, 3885);   // just above the first midpoint
    drive_sample(1, 3884);   // on the first midpoint
    drive_sample(2, 4095);   // doubled rail at full scale
    drive_sample(2, 0);
    drive_sample(6, 4095);   // voltage channel without doubling
    drive_sample(3, 2049);   // reset threshold, equal: not good
    drive_sample(3, 2050);   // one mV above: good
    drive_sample(23, 4095);  // highest channel
    drive_sample(24, 4095);  // channels past the role bits read as unused
    drive_sample(31, 4095);
    finish_burst();

    cfg_write(RegThresh, {52'hF_FFFF_FFFF_FFFF, 12'd0});
    drive_sample(3, 0);
    drive_sample(3, 2);
    finish_burst();

    // Threshold above range: the flag can never read good.
    cfg_write(RegThresh, {52'd0, 12'd4095});
    drive_sample(7, 4095);
    finish_burst();

    // Write to the unmapped slot must leave all registers alone.
    cfg_write(RegUnmapped, {$urandom, $urandom});
    drive_sample(3, 4095);
    drive_sample(1, 2048);
    finish_burst();

    cfg_write(RegThresh, {52'd0, 12'd3300});
    drive_sample(3, 4095);
    finish_burst();

    // Random phases with a fresh setting each; the last runs with no idling on either side.
    for (p = 0; p < RandomPhases; p++) begin
      case (p)
        0: begin
          roles_v  = {24{KIND_FLAG}};
          mask_v   = '0;
          thresh_v = 12'($urandom_range(0, 3300));
        end
        1: begin
          roles_v  = {24{KIND_TEMP}};
          mask_v   = 24'($urandom);
          thresh_v = 12'd1650;
        end
        2: begin
          roles_v  = {24{KIND_VOLT}};
          mask_v   = '1;
          thresh_v = 12'd3300;
        end
        3: begin
          roles_v  = '0;
          mask_v   = 24'($urandom);
          thresh_v = 12'd0;
        end
        default: begin
          roles_v = {16'($urandom), 32'($urandom)};
          mask_v  = 24'($urandom);
          case ($urandom_range(0, 3))
            0: thresh_v = 12'd0;
            1: thresh_v = 12'd3300;
            2: thresh_v = 12'd4095;
            default: thresh_v = 12'($urandom_range(0, 3300));
          endcase
        end
      endcase
      v = {$urandom, $urandom};
      v[47:0] = roles_v;
      cfg_write(RegRoles, v);
      v = {$urandom, $urandom};
      v[23:0] = mask_v;
      cfg_write(RegDouble, v);
      v = {$urandom, $urandom};
      v[11:0] = thresh_v;
      cfg_write(RegThresh, v);

      if (p == RandomPhases - 1) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = (p % 3 == 0) ? 0 : 25;
        out_stall_pct = (p % 3 == 1) ? 0 : 25;
      end

      for (n = 0; n < PhaseItems; n++) begin
        ch = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 23) : $urandom_range(24, 31);
        case ($urandom_range(0, 9))
          0: code = $urandom_range(0, 1) ? 4095 : 0;
          1, 2: begin
            // Land on either side of a table midpoint.
            k    = $urandom_range(0, TableLen - 2);
            mid  = (ThermistorMv[k] + ThermistorMv[k + 1]) / 2;
            code = ((mid + 1) * 4096 + 3299) / 3300 - $urandom_range(0, 1);
          end
          3: begin
            // Land on either side of the flag threshold.
            th = int'(sb.threshold);
            if (th >= 3300)
              code = 4095 - $urandom_range(0, 3);
            else
              code = ((th + 1) * 4096 + 3299) / 3300 - $urandom_range(0, 1);
            if (code > 4095) code = 4095;
            if (code < 0) code = 0;
          end
          default: code = $urandom_range(0, 4095);
        endcase
        drive_sample(ch, code);
      end
      finish_burst();
    end

    // Let the pipeline settle a little longer before judging.
    repeat (8) @(posedge clk);
    failures = sb.mismatches + sb.pending_readings.size();
    $display("testbench: %0d readings checked, %0d register writes, %0d setting phases",
             sb.checked, cfg_writes, RandomPhases + 5);
    $display("testbench: %0d mismatches, all four channel roles and one long output stall",
             sb.mismatches);
    if (failures == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
